// File: rtl/tebt_pkg.sv
package tebt_pkg;

  localparam int COORD_BITS  = 16;
  localparam int FRAC_BITS   = 16;
  localparam int DIFF_W      = COORD_BITS + 1;
  localparam int EDGE_W      = 2 * DIFF_W;
  localparam int REM_W       = EDGE_W + 1;
  localparam int WEIGHT_W    = FRAC_BITS + 1;
  localparam int DIV_STEPS   = FRAC_BITS + 1;
  localparam int IDX_W       = 3;

  localparam logic [IDX_W-1:0] REG_V0X = 3'd0;
  localparam logic [IDX_W-1:0] REG_V0Y = 3'd1;
  localparam logic [IDX_W-1:0] REG_V1X = 3'd2;
  localparam logic [IDX_W-1:0] REG_V1Y = 3'd3;
  localparam logic [IDX_W-1:0] REG_V2X = 3'd4;
  localparam logic [IDX_W-1:0] REG_V2Y = 3'd5;

  localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = WEIGHT_W'(1) << FRAC_BITS;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
  } vert_t;

  typedef struct packed {
    logic                use_w;
    logic                sat;
    logic [REM_W-1:0]    rem;
    logic [WEIGHT_W-1:0] q;
  } lane_t;

  typedef struct packed {
    logic                     in_tri;
    logic                     zero;
    logic signed [EDGE_W-1:0] eab;
    logic signed [EDGE_W-1:0] ebc;
    logic signed [EDGE_W-1:0] eca;
    logic [EDGE_W-1:0]        na;
    lane_t [2:0]              lane;
  } div_t;

  function automatic logic signed [DIFF_W-1:0] diff(
      input logic signed [COORD_BITS-1:0] a,
      input logic signed [COORD_BITS-1:0] b);
    diff = DIFF_W'(a) - DIFF_W'(b);
  endfunction

  function automatic logic [EDGE_W-1:0] mag(input logic signed [EDGE_W-1:0] v);
    mag = v[EDGE_W-1] ? EDGE_W'(-v) : EDGE_W'(v);
  endfunction

endpackage

// File: rtl/tebt_edge.sv
module tebt_edge (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 adv,
  input  logic                 in_vld,
  input  logic signed [15:0]   px,
  input  logic signed [15:0]   py,
  input  tebt_pkg::vert_t      v0,
  input  tebt_pkg::vert_t      v1,
  input  tebt_pkg::vert_t      v2,
  output logic                 out_vld,
  output tebt_pkg::div_t       out_d
);

  logic signed [tebt_pkg::EDGE_W-1:0] pa [4];
  logic signed [tebt_pkg::EDGE_W-1:0] pb [4];
  logic signed [tebt_pkg::EDGE_W-1:0] e  [4];
  logic                               vld1, vld2;
  tebt_pkg::div_t                     d3_next;
  logic [tebt_pkg::EDGE_W-1:0]        ne [3];

  // products: index 0 ab, 1 bc, 2 ca, 3 area
  always_ff @(posedge clk) begin
    if (adv) begin
      pa[0] <= tebt_pkg::diff(px, v0.x) * tebt_pkg::diff(v1.y, v0.y);
      pb[0] <= tebt_pkg::diff(py, v0.y) * tebt_pkg::diff(v1.x, v0.x);
      pa[1] <= tebt_pkg::diff(px, v1.x) * tebt_pkg::diff(v2.y, v1.y);
      pb[1] <= tebt_pkg::diff(py, v1.y) * tebt_pkg::diff(v2.x, v1.x);
      pa[2] <= tebt_pkg::diff(px, v2.x) * tebt_pkg::diff(v0.y, v2.y);
      pb[2] <= tebt_pkg::diff(py, v2.y) * tebt_pkg::diff(v0.x, v2.x);
      pa[3] <= tebt_pkg::diff(v2.x, v0.x) * tebt_pkg::diff(v1.y, v0.y);
      pb[3] <= tebt_pkg::diff(v2.y, v0.y) * tebt_pkg::diff(v1.x, v0.x);
      for (int i = 0; i < 4; i++) begin
        e[i] <= pa[i] - pb[i];
      end
      out_d <= d3_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld1    <= 1'b0;
      vld2    <= 1'b0;
      out_vld <= 1'b0;
    end else if (adv) begin
      vld1    <= in_vld;
      vld2    <= vld1;
      out_vld <= vld2;
    end
  end

  // lane 0 carries edge_bc, lane 1 edge_ca, lane 2 edge_ab
  always_comb begin
    d3_next        = '0;
    d3_next.eab    = e[0];
    d3_next.ebc    = e[1];
    d3_next.eca    = e[2];
    d3_next.na     = tebt_pkg::mag(e[3]);
    d3_next.zero   = (e[3] == '0);
    d3_next.in_tri = (!e[0][tebt_pkg::EDGE_W-1] && !e[1][tebt_pkg::EDGE_W-1]
                      && !e[2][tebt_pkg::EDGE_W-1])
                  || (e[0][tebt_pkg::EDGE_W-1] && e[1][tebt_pkg::EDGE_W-1]
                      && e[2][tebt_pkg::EDGE_W-1]);
    ne[0] = tebt_pkg::mag(e[1]);
    ne[1] = tebt_pkg::mag(e[2]);
    ne[2] = tebt_pkg::mag(e[0]);
    for (int i = 0; i < 3; i++) begin
      d3_next.lane[i].use_w = d3_next.in_tri && !d3_next.zero
          && (e[(i + 1) % 3][tebt_pkg::EDGE_W-1] == e[3][tebt_pkg::EDGE_W-1]);
      // quotient of two or more: clamp without dividing
      d3_next.lane[i].sat = {1'b0, ne[i]} >= {d3_next.na, 1'b0};
      d3_next.lane[i].rem = {1'b0, ne[i]};
      d3_next.lane[i].q   = '0;
    end
  end

endmodule

// File: rtl/tebt_div_step.sv
module tebt_div_step (
  input  logic           clk,
  input  logic           rst,
  input  logic           adv,
  input  logic           in_vld,
  input  tebt_pkg::div_t in_d,
  output logic           out_vld,
  output tebt_pkg::div_t out_d
);

  tebt_pkg::div_t              d_next;
  logic                        bit_q [3];
  logic [tebt_pkg::REM_W-1:0]  r     [3];

  // one restoring step per lane, then shift the remainder
  always_comb begin
    d_next = in_d;
    for (int i = 0; i < 3; i++) begin
      bit_q[i] = in_d.lane[i].rem >= {1'b0, in_d.na};
      r[i]     = bit_q[i] ? in_d.lane[i].rem - {1'b0, in_d.na} : in_d.lane[i].rem;
      d_next.lane[i].rem = {r[i][tebt_pkg::REM_W-2:0], 1'b0};
      d_next.lane[i].q   = {in_d.lane[i].q[tebt_pkg::WEIGHT_W-2:0], bit_q[i]};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_d <= d_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (adv) begin
      out_vld <= in_vld;
    end
  end

endmodule

// File: rtl/triangle_edge_barycentric_test.sv
// Channel | Signals                                   | Direction
// input   | in_valid, in_ready, point_x, point_y      | in
// result  | out_valid, out_ready, inside_res .. zero  | out
// config  | cfg_we, cfg_index, cfg_data               | in
//
// One item enters per cycle while no result is held; each result passes through
// the edge arithmetic (product, edge and setup registers), 17 restoring division
// steps (one quotient bit per stage) and the output register.
// Reset clears all valid bits and loads the default triangle (2,2) (6,5) (7,1).
// A held result stalls the whole pipeline; in_ready is high when out_ready is or no result is held.
module triangle_edge_barycentric_test (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic signed [15:0]   point_x,
  input  logic signed [15:0]   point_y,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 inside_res,
  output logic signed [33:0]   edge_ab,
  output logic signed [33:0]   edge_bc,
  output logic signed [33:0]   edge_ca,
  output logic [16:0]          weight_first,
  output logic [16:0]          weight_second,
  output logic [16:0]          weight_third,
  output logic                 zero_area,
  input  logic                 cfg_we,
  input  logic [2:0]           cfg_index,
  input  logic [15:0]          cfg_data
);

  tebt_pkg::vert_t  v0, v1, v2;
  logic             adv;
  logic             vld [tebt_pkg::DIV_STEPS+1];
  tebt_pkg::div_t   dch [tebt_pkg::DIV_STEPS+1];
  tebt_pkg::div_t   fin;
  logic [tebt_pkg::WEIGHT_W-1:0] w [3];

  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= '{x: 16'sd2, y: 16'sd2};
      v1 <= '{x: 16'sd6, y: 16'sd5};
      v2 <= '{x: 16'sd7, y: 16'sd1};
    end else if (cfg_we) begin
      unique case (cfg_index)
        tebt_pkg::REG_V0X: v0.x <= cfg_data;
        tebt_pkg::REG_V0Y: v0.y <= cfg_data;
        tebt_pkg::REG_V1X: v1.x <= cfg_data;
        tebt_pkg::REG_V1Y: v1.y <= cfg_data;
        tebt_pkg::REG_V2X: v2.x <= cfg_data;
        tebt_pkg::REG_V2Y: v2.y <= cfg_data;
        default: ;
      endcase
    end
  end

  tebt_edge u_edge (
    .clk     (clk),
    .rst     (rst),
    .adv     (adv),
    .in_vld  (in_valid),
    .px      (point_x),
    .py      (point_y),
    .v0      (v0),
    .v1      (v1),
    .v2      (v2),
    .out_vld (vld[0]),
    .out_d   (dch[0])
  );

  for (genvar s = 0; s < tebt_pkg::DIV_STEPS; s++) begin : g_div
    tebt_div_step u_step (
      .clk     (clk),
      .rst     (rst),
      .adv     (adv),
      .in_vld  (vld[s]),
      .in_d    (dch[s]),
      .out_vld (vld[s+1]),
      .out_d   (dch[s+1])
    );
  end

  assign fin = dch[tebt_pkg::DIV_STEPS];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (!fin.lane[i].use_w) begin
        w[i] = '0;
      end else if (fin.lane[i].sat || fin.lane[i].q > tebt_pkg::WEIGHT_ONE) begin
        w[i] = tebt_pkg::WEIGHT_ONE;
      end else begin
        w[i] = fin.lane[i].q;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      inside_res    <= fin.in_tri;
      edge_ab       <= fin.eab;
      edge_bc       <= fin.ebc;
      edge_ca       <= fin.eca;
      weight_first  <= w[0];
      weight_second <= w[1];
      weight_third  <= w[2];
      zero_area     <= fin.zero;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= vld[tebt_pkg::DIV_STEPS];
    end
  end

  a_zero_no_weight: assert property (@(posedge clk) disable iff (rst)
      out_valid && zero_area |-> weight_first == '0 && weight_second == '0
                                 && weight_third == '0)
    else $error("weight given for zero area");

  a_outside_no_weight: assert property (@(posedge clk) disable iff (rst)
      out_valid && !inside_res |-> weight_first == '0 && weight_second == '0
                                   && weight_third == '0)
    else $error("weight given for outside point");

  a_weight_clamped: assert property (@(posedge clk) disable iff (rst)
      out_valid |-> weight_first <= tebt_pkg::WEIGHT_ONE
                 && weight_second <= tebt_pkg::WEIGHT_ONE
                 && weight_third <= tebt_pkg::WEIGHT_ONE)
    else $error("weight above one");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
      out_valid && !out_ready |=> out_valid && $stable(weight_first)
                                  && $stable(edge_ab))
    else $error("result lost under stall");

  a_ready_tracks: assert property (@(posedge clk) disable iff (rst)
      in_ready == (!out_valid || out_ready))
    else $error("input taken while pipeline held");

endmodule

// File: dv/tb.sv
`timescale 1ns / 100ps

module tb;

  typedef struct packed {
    logic               in_tri;
    logic signed [33:0] eab;
    logic signed [33:0] ebc;
    logic signed [33:0] eca;
    logic [16:0]        w0;
    logic [16:0]        w1;
    logic [16:0]        w2;
    logic               zero;
  } hit_t;

  typedef struct {
    logic signed [15:0] px;
    logic signed [15:0] py;
    logic               known;
    hit_t               res;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [15:0] point_x = '0;
  logic signed [15:0] point_y = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic inside_res;
  logic signed [33:0] edge_ab, edge_bc, edge_ca;
  logic [16:0] weight_first, weight_second, weight_third;
  logic zero_area;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;

  triangle_edge_barycentric_test uut (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    #50ms;
    $display("[FAIL] regression broken");
    $finish;
  end

  tebt_pkg::vert_t tri_v [3];
  hit_t expected_hits [$];
  int errors = 0;
  int n_items = 0;
  int n_inside = 0;
  int n_zero = 0;

  function automatic logic signed [63:0] cross2(
      input tebt_pkg::vert_t o, input tebt_pkg::vert_t a, input logic signed [63:0] bx,
      input logic signed [63:0] by);
    logic signed [63:0] ox, oy, ax, ay;
    ox = o.x; oy = o.y; ax = a.x; ay = a.y;
    cross2 = (bx - ox) * (ay - oy) - (by - oy) * (ax - ox);
  endfunction

  function automatic logic [16:0] bary(input logic signed [63:0] e,
                                       input logic signed [63:0] area);
    logic [63:0] ne, na, q;
    if (area == 0 || (e != 0 && ((e < 0) != (area < 0)))) return '0;
    ne = e < 0 ? -e : e;
    na = area < 0 ? -area : area;
    q = (ne << tebt_pkg::FRAC_BITS) / na;
    if (q > 64'd65536) q = 64'd65536;
    return q[16:0];
  endfunction

  function automatic hit_t predict_hit(input logic signed [15:0] px,
                                       input logic signed [15:0] py);
    logic signed [63:0] x, y, ab, bc, ca, area;
    int nn;
    hit_t h;
    x = px; y = py;
    ab = cross2(tri_v[0], tri_v[1], x, y);
    bc = cross2(tri_v[1], tri_v[2], x, y);
    ca = cross2(tri_v[2], tri_v[0], x, y);
    area = cross2(tri_v[0], tri_v[1], tri_v[2].x, tri_v[2].y);
    nn = (ab >= 0) + (bc >= 0) + (ca >= 0);
    h = '0;
    h.in_tri = (nn == 3 || nn == 0);
    h.eab = ab[33:0]; h.ebc = bc[33:0]; h.eca = ca[33:0];
    h.zero = (area == 0);
    // negative quotient with a zero edge is still zero, so the sign test is safe
    if (h.in_tri && area != 0) begin
      h.w0 = bary(bc, area);
      h.w1 = bary(ca, area);
      h.w2 = bary(ab, area);
    end
    return h;
  endfunction

  task automatic set_vertex(input int k, input logic signed [15:0] x,
                            input logic signed [15:0] y);
    logic [2:0] ix, iy;
    ix = (k == 0) ? tebt_pkg::REG_V0X : (k == 1) ? tebt_pkg::REG_V1X : tebt_pkg::REG_V2X;
    iy = (k == 0) ? tebt_pkg::REG_V0Y : (k == 1) ? tebt_pkg::REG_V1Y : tebt_pkg::REG_V2Y;
    @(posedge clk);
    cfg_we <= 1'b1; cfg_index <= ix; cfg_data <= x;
    @(posedge clk);
    cfg_index <= iy; cfg_data <= y;
    @(posedge clk);
    cfg_we <= 1'b0;
    tri_v[k].x = x; tri_v[k].y = y;
  endtask

  task automatic drain();
    int guard;
    guard = 0;
    while (expected_hits.size() != 0 && guard < 100000) begin
      @(posedge clk);
      guard++;
    end
    repeat (30) @(posedge clk);
  endtask

  // send one item; gap cycles of idle first
  task automatic send_point(input logic signed [15:0] x, input logic signed [15:0] y,
                            input int gap, input logic known, input hit_t res);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1; point_x <= x; point_y <= y;
    if (known) expected_hits.push_back(res);
    else expected_hits.push_back(predict_hit(x, y));
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    n_items++;
  endtask

  task automatic compare_hit(input hit_t e);
    if (inside_res !== e.in_tri)
      $error("inside_res exp %0d got %0d", e.in_tri, inside_res);
    if (edge_ab !== e.eab) $error("edge_ab exp %0d got %0d", e.eab, edge_ab);
    if (edge_bc !== e.ebc) $error("edge_bc exp %0d got %0d", e.ebc, edge_bc);
    if (edge_ca !== e.eca) $error("edge_ca exp %0d got %0d", e.eca, edge_ca);
    if (weight_first !== e.w0)
      $error("weight_first exp %0d got %0d", e.w0, weight_first);
    if (weight_second !== e.w1)
      $error("weight_second exp %0d got %0d", e.w1, weight_second);
    if (weight_third !== e.w2)
      $error("weight_third exp %0d got %0d", e.w2, weight_third);
    if (zero_area !== e.zero) $error("zero_area exp %0d got %0d", e.zero, zero_area);
    if (inside_res !== e.in_tri || edge_ab !== e.eab || edge_bc !== e.ebc ||
        edge_ca !== e.eca || weight_first !== e.w0 || weight_second !== e.w1 ||
        weight_third !== e.w2 || zero_area !== e.zero)
      errors++;
  endtask

  // result side: check and stall on its own pattern
  int stall_mode = 0;
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (expected_hits.size() == 0) begin
        $error("result with no item outstanding");
        errors++;
      end else begin
        compare_hit(expected_hits.pop_front());
        if (inside_res) n_inside++;
        if (zero_area) n_zero++;
      end
    end
    if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= ($urandom_range(0, 3) != 0);
      2: out_ready <= ($urandom_range(0, 1) == 0);
      default: out_ready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  row_t rows [$];

  function automatic row_t mk(input int x, input int y, input logic known,
                              input hit_t r);
    row_t t;
    t.px = x; t.py = y; t.known = known; t.res = r;
    return t;
  endfunction

  initial begin
    hit_t h, nil;
    int burst, px, py;
    logic signed [15:0] ax, ay, bx, by, cx, cy;
    nil = '0;
    tri_v[0] = '{x: 16'sd2, y: 16'sd2};
    tri_v[1] = '{x: 16'sd6, y: 16'sd5};
    tri_v[2] = '{x: 16'sd7, y: 16'sd1};
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // default triangle has area 19; the first vertex gives two zero edges and
    // edge_bc equal to the area, so it is inside with all weight on the first
    h = '0; h.in_tri = 1'b1; h.eab = 34'sd0; h.ebc = 34'sd19; h.eca = 34'sd0;
    h.w0 = 17'd65536;
    rows.push_back(mk(2, 2, 1'b1, h));
    rows.push_back(mk(5, 3, 1'b0, nil));
    rows.push_back(mk(6, 2, 1'b0, nil));
    rows.push_back(mk(0, 0, 1'b0, nil));
    rows.push_back(mk(32767, 32767, 1'b0, nil));
    rows.push_back(mk(-32768, -32768, 1'b0, nil));
    rows.push_back(mk(-32768, 32767, 1'b0, nil));
    rows.push_back(mk(32767, -32768, 1'b0, nil));
    rows.push_back(mk(-1, -1, 1'b0, nil));
    foreach (rows[i]) send_point(rows[i].px, rows[i].py, 0, rows[i].known, rows[i].res);
    rows.delete();
    in_valid <= 1'b0;
    drain();

    // extreme triangle: widest edges
    set_vertex(0, -16'sd32768, -16'sd32768);
    set_vertex(1, 16'sd32767, -16'sd32768);
    set_vertex(2, -16'sd32768, 16'sd32767);
    send_point(-16'sd32768, -16'sd32768, 0, 1'b0, nil);
    send_point(16'sd32767, 16'sd32767, 0, 1'b0, nil);
    send_point(16'sd0, 16'sd0, 0, 1'b0, nil);
    send_point(-16'sd32768, 16'sd32767, 0, 1'b0, nil);
    send_point(16'sd32767, -16'sd32768, 1, 1'b0, nil);
    in_valid <= 1'b0;
    drain();

    // degenerate: all vertices on a line, zero area regardless of the point
    set_vertex(0, 16'sd0, 16'sd0);
    set_vertex(1, 16'sd10, 16'sd10);
    set_vertex(2, 16'sd20, 16'sd20);
    h = '0; h.in_tri = 1'b1; h.zero = 1'b1;
    send_point(16'sd5, 16'sd5, 0, 1'b1, h);
    send_point(16'sd3, -16'sd7, 0, 1'b0, nil);
    in_valid <= 1'b0;
    drain();

    // clockwise triangle, then reversed winding: all-negative edges also count inside
    set_vertex(0, 16'sd0, 16'sd0);
    set_vertex(1, 16'sd0, 16'sd100);
    set_vertex(2, 16'sd100, 16'sd0);
    send_point(16'sd10, 16'sd10, 0, 1'b0, nil);
    send_point(16'sd0, 16'sd0, 0, 1'b0, nil);
    send_point(16'sd50, 16'sd50, 0, 1'b0, nil);
    in_valid <= 1'b0;
    drain();
    set_vertex(1, 16'sd100, 16'sd0);
    set_vertex(2, 16'sd0, 16'sd100);
    send_point(16'sd10, 16'sd10, 0, 1'b0, nil);
    send_point(16'sd33, 16'sd33, 0, 1'b0, nil);
    in_valid <= 1'b0;
    drain();

    // random phases: new triangle, then points mostly near it
    for (int ph = 0; ph < 14; ph++) begin
      case (ph % 4)
        0: begin
          ax = $urandom; ay = $urandom; bx = $urandom;
          by = $urandom; cx = $urandom; cy = $urandom;
        end
        1: begin
          ax = $urandom_range(0, 400) - 200; ay = $urandom_range(0, 400) - 200;
          bx = $urandom_range(0, 400) - 200; by = $urandom_range(0, 400) - 200;
          cx = $urandom_range(0, 400) - 200; cy = $urandom_range(0, 400) - 200;
        end
        2: begin
          ax = $urandom_range(0, 40); ay = ax; bx = $urandom_range(0, 40);
          by = bx; cx = $urandom; cy = cx;
        end
        default: begin
          ax = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
          ay = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
          bx = $urandom; by = $urandom; cx = $urandom; cy = $urandom;
        end
      endcase
      set_vertex(0, ax, ay);
      set_vertex(1, bx, by);
      set_vertex(2, cx, cy);
      for (int k = 0; k < 50; k++) begin
        burst = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0;
        if ($urandom_range(0, 4) == 0) begin
          px = $urandom; py = $urandom;
        end else begin
          // convex mix of the vertices, plus a little jitter
          int a, b, c, s;
          a = $urandom_range(0, 100); b = $urandom_range(0, 100);
          c = $urandom_range(0, 100); s = a + b + c + 1;
          px = (a * ax + b * bx + c * cx) / s + $urandom_range(0, 4) - 2;
          py = (a * ay + b * by + c * cy) / s + $urandom_range(0, 4) - 2;
        end
        send_point(px, py, (ph == 5 && k == 25) ? 0 : burst, 1'b0, nil);
        if (ph == 5 && k == 25) begin
          in_valid <= 1'b0;
          drain();
        end
      end
      in_valid <= 1'b0;
      drain();
    end

    $display("covered %0d points, %0d inside, %0d on zero-area triangles",
             n_items, n_inside, n_zero);
    if (errors == 0 && expected_hits.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule

// File: sim.f
rtl/tebt_pkg.sv
rtl/tebt_edge.sv
rtl/tebt_div_step.sv
rtl/triangle_edge_barycentric_test.sv
dv/tb.sv
